>>> design/tlt_pkg.sv
package tlt_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_INT   = 3'd2,
    MODE_PLUS  = 3'd3,
    MODE_STAR  = 3'd4,
    MODE_AMP1  = 3'd5,
    MODE_AMP2  = 3'd6
  } mode_e;

  typedef enum logic [4:0] {
    TK_PROGRAM = 5'd0,
    TK_LBRACE  = 5'd1,
    TK_RBRACE  = 5'd2,
    TK_SEMI    = 5'd3,
    TK_READ    = 5'd4,
    TK_WRITE   = 5'd5,
    TK_IF      = 5'd6,
    TK_LPAREN  = 5'd7,
    TK_RPAREN  = 5'd8,
    TK_ASSIGN  = 5'd9,
    TK_QUEST   = 5'd10,
    TK_COLON   = 5'd11,
    TK_LBRACK  = 5'd12,
    TK_RBRACK  = 5'd13,
    TK_DOT     = 5'd14,
    TK_LENGTH  = 5'd15,
    TK_NEW     = 5'd16,
    TK_BANG    = 5'd17,
    TK_PLUS_EQ = 5'd18,
    TK_STAR_EQ = 5'd19,
    TK_AND_EQ  = 5'd20,
    TK_IDENT   = 5'd21,
    TK_INT     = 5'd22,
    TK_ERROR   = 5'd23,
    TK_END     = 5'd24
  } token_e;

  localparam int unsigned NUM_KW = 6;
  localparam int unsigned POS_MAX = 15;

  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_AMP    = "&";
  localparam logic [7:0] CH_EQ     = "=";

  // keyword text right-justified, first character in the highest used byte
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'("program"), 64'("read"), 64'("write"), 64'("if"), 64'("length"), 64'("new")
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd7, 4'd4, 4'd5, 4'd2, 4'd6, 4'd3};
  localparam token_e KW_CODE [NUM_KW] = '{TK_PROGRAM, TK_READ, TK_WRITE, TK_IF,
                                          TK_LENGTH, TK_NEW};

  typedef struct packed {
    mode_e      mode;
    logic [5:0] cand;
    logic [3:0] pos;
  } scan_t;

  typedef struct packed {
    logic   hit;
    token_e kind;
  } tok_t;

  function automatic logic kw_match(int unsigned k, logic [3:0] p, logic [7:0] c);
    logic [3:0] sh;
    sh = KW_LEN[k] - 4'd1 - p;
    return (p < KW_LEN[k]) && (KW_TEXT[k][{sh[2:0], 3'b000} +: 8] == c);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic tok_t punct_tok(logic [7:0] c);
    tok_t t;
    t.hit  = 1'b1;
    t.kind = TK_ERROR;
    case (c)
      "{":     t.kind = TK_LBRACE;
      "}":     t.kind = TK_RBRACE;
      ";":     t.kind = TK_SEMI;
      "(":     t.kind = TK_LPAREN;
      ")":     t.kind = TK_RPAREN;
      "=":     t.kind = TK_ASSIGN;
      "?":     t.kind = TK_QUEST;
      ":":     t.kind = TK_COLON;
      "[":     t.kind = TK_LBRACK;
      "]":     t.kind = TK_RBRACK;
      ".":     t.kind = TK_DOT;
      "!":     t.kind = TK_BANG;
      default: t.hit  = 1'b0;
    endcase
    return t;
  endfunction

endpackage

>>> design/tlt_step.sv
module tlt_step #(
  parameter int unsigned ERR_BITS = 16
) (
  input  logic [7:0]          char_code_i,
  input  logic                source_end_i,
  input  tlt_pkg::scan_t      scan_i,
  input  logic [ERR_BITS-1:0] tally_i,
  output tlt_pkg::scan_t      scan_o,
  output logic [ERR_BITS-1:0] tally_o,
  output tlt_pkg::tok_t       res0_o,
  output tlt_pkg::tok_t       res1_o,
  output logic [ERR_BITS-1:0] err0_o,
  output logic [ERR_BITS-1:0] err1_o
);
  import tlt_pkg::*;

  tok_t                pend;
  tok_t                idle;
  tok_t                punct;
  logic                idle_handle;
  logic                alnum;
  logic [5:0]          cand_take;
  logic [5:0]          cand_first;
  logic [3:0]          pos_inc;
  token_e              ident_kind;
  logic [ERR_BITS-1:0] tally1;
  logic [ERR_BITS-1:0] tally2;

  function automatic logic [ERR_BITS-1:0] sat_inc(logic [ERR_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign alnum   = is_alpha(char_code_i) || is_digit(char_code_i);
  assign punct   = punct_tok(char_code_i);
  assign pos_inc = (scan_i.pos < 4'(POS_MAX)) ? scan_i.pos + 4'd1 : 4'(POS_MAX);

  always_comb begin
    for (int unsigned k = 0; k < NUM_KW; k++) begin
      cand_take[k]  = scan_i.cand[k] && kw_match(k, scan_i.pos, char_code_i);
      cand_first[k] = kw_match(k, 4'd0, char_code_i);
    end
  end

  always_comb begin
    ident_kind = TK_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (scan_i.cand[k] && (scan_i.pos == KW_LEN[k])) begin
        ident_kind = KW_CODE[k];
      end
    end
  end

  always_comb begin
    pend        = '{hit: 1'b0, kind: TK_ERROR};
    idle        = '{hit: 1'b0, kind: TK_ERROR};
    idle_handle = 1'b1;
    scan_o      = scan_i;
    scan_o.mode = MODE_IDLE;

    case (scan_i.mode)
      MODE_IDENT: begin
        if (!source_end_i && alnum) begin
          idle_handle = 1'b0;
          scan_o.mode = MODE_IDENT;
          scan_o.cand = cand_take;
          scan_o.pos  = pos_inc;
        end else begin
          pend = '{hit: 1'b1, kind: ident_kind};
        end
      end
      MODE_INT: begin
        if (!source_end_i && is_digit(char_code_i)) begin
          idle_handle = 1'b0;
          scan_o.mode = MODE_INT;
        end else begin
          pend = '{hit: 1'b1, kind: TK_INT};
        end
      end
      MODE_PLUS, MODE_STAR, MODE_AMP2: begin
        pend.hit = 1'b1;
        if (!source_end_i) begin
          idle_handle = 1'b0;
          if (char_code_i == CH_EQ) begin
            pend.kind = (scan_i.mode == MODE_PLUS) ? TK_PLUS_EQ :
                        (scan_i.mode == MODE_STAR) ? TK_STAR_EQ : TK_AND_EQ;
          end
        end
      end
      MODE_AMP1: begin
        if (source_end_i) begin
          pend.hit = 1'b1;
        end else begin
          idle_handle = 1'b0;
          if (char_code_i == CH_AMP) begin
            scan_o.mode = MODE_AMP2;
          end else begin
            pend.hit = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (idle_handle) begin
      if (source_end_i || (char_code_i == CH_DOLLAR)) begin
        idle = '{hit: 1'b1, kind: TK_END};
      end else if (is_space(char_code_i)) begin
        idle.hit = 1'b0;
      end else if (punct.hit) begin
        idle = punct;
      end else if (char_code_i == CH_PLUS) begin
        scan_o.mode = MODE_PLUS;
      end else if (char_code_i == CH_STAR) begin
        scan_o.mode = MODE_STAR;
      end else if (char_code_i == CH_AMP) begin
        scan_o.mode = MODE_AMP1;
      end else if (is_alpha(char_code_i)) begin
        scan_o.mode = MODE_IDENT;
        scan_o.cand = cand_first;
        scan_o.pos  = 4'd1;
      end else if (is_digit(char_code_i)) begin
        scan_o.mode = MODE_INT;
      end else begin
        idle = '{hit: 1'b1, kind: TK_ERROR};
      end
    end
  end

  assign tally1 = (pend.hit && (pend.kind == TK_ERROR)) ? sat_inc(tally_i) : tally_i;
  assign tally2 = (idle.hit && (idle.kind == TK_ERROR)) ? sat_inc(tally1) : tally1;

  assign res0_o  = pend.hit ? pend : idle;
  assign res1_o  = pend.hit ? idle : tok_t'{hit: 1'b0, kind: TK_ERROR};
  assign err0_o  = pend.hit ? tally1 : tally2;
  assign err1_o  = tally2;
  assign tally_o = (idle.hit && (idle.kind == TK_END)) ? '0 : tally2;

endmodule

>>> design/toy_language_tokenizer_unit.sv
// A character waits in the input stage register; its tokens go to the output queue.
// Throughput: one character per cycle while the queue has room and each gives at most
// one token; a character that ends an identifier or integer and also yields a token
// gives two queued tokens. The limit is the single-token-per-cycle output queue
// (four entries). Reset (rst_ni low, asynchronous) empties the input stage and output
// queue, returns scanning to idle and clears the error count.
module toy_language_tokenizer_unit #(
  parameter int unsigned ERROR_COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        source_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_kind_o,
  output logic        last_of_run_o,
  output logic [15:0] lexical_errors_o
);
  import tlt_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    token_e      kind;
    logic        last;
    logic [15:0] errs;
  } entry_t;

  logic                        stg_v_q;
  logic [7:0]                  stg_char_q;
  logic                        stg_end_q;
  scan_t                       scan_q, scan_d;
  logic [ERROR_COUNT_BITS-1:0] tally_q, tally_d;
  tok_t                        res0, res1;
  logic [ERROR_COUNT_BITS-1:0] err0, err1;

  entry_t                      q_mem_q [QDEPTH];
  logic [QAW-1:0]              wr_ptr_q, rd_ptr_q;
  logic [QAW:0]                cnt_q, cnt_d;

  logic                        go;
  logic                        in_acc;
  logic                        pop;
  logic [1:0]                  push_n;
  logic [31:0]                 err0_ext, err1_ext;

  tlt_step #(
    .ERR_BITS(ERROR_COUNT_BITS)
  ) u_step (
    .char_code_i (stg_char_q),
    .source_end_i(stg_end_q),
    .scan_i      (scan_q),
    .tally_i     (tally_q),
    .scan_o      (scan_d),
    .tally_o     (tally_d),
    .res0_o      (res0),
    .res1_o      (res1),
    .err0_o      (err0),
    .err1_o      (err1)
  );

  assign go         = stg_v_q && (cnt_q <= (QAW + 1)'(QDEPTH - 2));
  assign in_stall_o = stg_v_q && !go;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign push_n      = go ? (2'(res0.hit) + 2'(res1.hit)) : 2'd0;
  assign cnt_d       = cnt_q + (QAW + 1)'(push_n) - (QAW + 1)'(pop);

  assign err0_ext = 32'(err0);
  assign err1_ext = 32'(err1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q  <= 1'b0;
      scan_q   <= '{mode: MODE_IDLE, cand: '0, pos: '0};
      tally_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_acc) begin
        stg_v_q <= 1'b1;
      end else if (go) begin
        stg_v_q <= 1'b0;
      end
      if (go) begin
        scan_q   <= scan_d;
        tally_q  <= tally_d;
        wr_ptr_q <= wr_ptr_q + QAW'(push_n);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_char_q <= char_code_i;
      stg_end_q  <= source_end_i;
    end
    if (go && res0.hit) begin
      q_mem_q[wr_ptr_q] <= '{kind: res0.kind, last: !res1.hit, errs: err0_ext[15:0]};
    end
    if (go && res1.hit) begin
      q_mem_q[wr_ptr_q + 1'b1] <= '{kind: res1.kind, last: 1'b1, errs: err1_ext[15:0]};
    end
  end

  assign token_kind_o     = q_mem_q[rd_ptr_q].kind;
  assign last_of_run_o    = q_mem_q[rd_ptr_q].last;
  assign lexical_errors_o = q_mem_q[rd_ptr_q].errs;

endmodule

>>> design/tlt_checker.sv
module tlt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  char_code_i,
  input logic        source_end_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [4:0]  token_kind_o,
  input logic        last_of_run_o,
  input logic [15:0] lexical_errors_o
);
  import tlt_pkg::*;

  // both tokens of a character are queued together, so the second follows at once
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("second token of a run missing");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == TK_END) |-> last_of_run_o)
    else $error("end of source not last of its run");

  // only a finished identifier, keyword, integer or bad operator leads a pair
  a_lead_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |->
      (token_kind_o == TK_PROGRAM) || (token_kind_o == TK_READ) ||
      (token_kind_o == TK_WRITE) || (token_kind_o == TK_IF) ||
      (token_kind_o == TK_LENGTH) || (token_kind_o == TK_NEW) ||
      (token_kind_o == TK_IDENT) || (token_kind_o == TK_INT) ||
      (token_kind_o == TK_ERROR))
    else $error("unexpected leading token kind");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(token_kind_o) && $stable(lexical_errors_o))
    else $error("stalled output transaction changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(char_code_i) && $stable(source_end_i))
    else $error("stalled input transaction changed");

endmodule

bind toy_language_tokenizer_unit tlt_checker u_tlt_checker (.*);
